// File: design/tcst_pkg.sv
package tcst_pkg;

  localparam int Capacity = 32;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  // Entry layout: done, time, body, dvx, dvy, dvz
  localparam int EntW = 1 + 32 + 16 + 32 + 32 + 32;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_APPLY = 1'b1;

  localparam logic [1:0] RES_ACK = 2'd0;
  localparam logic [1:0] RES_FIRE = 2'd1;
  localparam logic [1:0] RES_SUM = 2'd2;

  localparam logic ST_OK = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] burn_time;
    logic [15:0] burn_body;
    logic signed [31:0] dv_x;
    logic signed [31:0] dv_y;
    logic signed [31:0] dv_z;
    logic [31:0] window_start;
    logic [31:0] window_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        status;
    logic [5:0]  slot_index;
    logic [15:0] out_body;
    logic signed [31:0] out_dv_x;
    logic signed [31:0] out_dv_y;
    logic signed [31:0] out_dv_z;
    logic [5:0]  applied_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        done;
    logic [31:0] t;
    logic [15:0] body;
    logic [31:0] dvx;
    logic [31:0] dvy;
    logic [31:0] dvz;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT_RD, S_SHIFT_WR, S_INSERT, S_SCAN_RD, S_SCAN_CHK, S_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic            load;      // capture input item
    logic            rd;        // read entry at index
    logic [IdxW-1:0] rd_addr;
    logic            wr;        // write entry
    logic [IdxW-1:0] wr_addr;
    logic            wr_sel;    // 0: write read data (shift/mark), 1: new entry
    logic            wr_mark;   // set done bit on the written data
    logic            inc_count;
    logic            inc_fired;
    logic            emit;
    logic [1:0]      emit_kind;
    logic            emit_full;
    logic [IdxW:0]   emit_slot;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CntW-1:0] count;
    logic          rd_gt;   // read entry time > new time
    logic          rd_hit;  // read entry not done and in window
  } dp_sts_t;

endpackage

// File: design/tcst_ram.sv
module tcst_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/tcst_datapath.sv
module tcst_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tcst_pkg::in_item_t  in_data,
  input  tcst_pkg::dp_cmd_t   cmd,
  output tcst_pkg::dp_sts_t   sts,
  output logic                out_valid,
  output tcst_pkg::out_item_t out_data
);

  tcst_pkg::in_item_t item_r;
  logic [tcst_pkg::CntW-1:0] count_r;
  logic [5:0] fired_r;
  logic [tcst_pkg::EntW-1:0] rdata;
  tcst_pkg::entry_t rd_ent;
  tcst_pkg::entry_t wr_ent;
  tcst_pkg::out_item_t res_nxt;
  logic out_valid_r;
  tcst_pkg::out_item_t out_r;

  assign rd_ent = tcst_pkg::entry_t'(rdata);

  // Pick write data: new command, or moved/marked copy of the read entry
  always_comb begin
    if (cmd.wr_sel) begin
      wr_ent.done = 1'b0;
      wr_ent.t = item_r.burn_time;
      wr_ent.body = item_r.burn_body;
      wr_ent.dvx = item_r.dv_x;
      wr_ent.dvy = item_r.dv_y;
      wr_ent.dvz = item_r.dv_z;
    end else begin
      wr_ent = rd_ent;
      if (cmd.wr_mark) begin
        wr_ent.done = 1'b1;
      end
    end
  end

  tcst_ram #(.Width(tcst_pkg::EntW), .Depth(tcst_pkg::Capacity)) u_ram (
    .clk  (clk),
    .we   (cmd.wr),
    .waddr(cmd.wr_addr),
    .wdata(wr_ent),
    .re   (cmd.rd),
    .raddr(cmd.rd_addr),
    .rdata(rdata)
  );

  // Hold the item and the counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (!rst_n) begin
      count_r <= '0;
      fired_r <= '0;
    end else begin
      if (cmd.inc_count) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.load) begin
        fired_r <= '0;
      end else if (cmd.inc_fired) begin
        fired_r <= fired_r + 6'd1;
      end
    end
  end

  assign sts.count = count_r;
  assign sts.rd_gt = rd_ent.t > item_r.burn_time;
  assign sts.rd_hit = !rd_ent.done && rd_ent.t >= item_r.window_start
                      && rd_ent.t < item_r.window_end;

  // Build the result
  always_comb begin
    res_nxt = '0;
    res_nxt.result_kind = cmd.emit_kind;
    case (cmd.emit_kind)
      tcst_pkg::RES_ACK: begin
        res_nxt.status = cmd.emit_full;
        res_nxt.slot_index = 6'(cmd.emit_slot);
        res_nxt.last = 1'b1;
      end
      tcst_pkg::RES_FIRE: begin
        res_nxt.out_body = rd_ent.body;
        res_nxt.out_dv_x = rd_ent.dvx;
        res_nxt.out_dv_y = rd_ent.dvy;
        res_nxt.out_dv_z = rd_ent.dvz;
      end
      default: begin
        res_nxt.applied_count = fired_r;
        res_nxt.last = 1'b1;
      end
    endcase
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
    if (cmd.emit) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

// File: design/tcst_ctrl.sv
module tcst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_kind,
  input  tcst_pkg::dp_sts_t sts,
  output tcst_pkg::dp_cmd_t cmd,
  output logic              busy
);

  tcst_pkg::state_t state_r, state_nxt;
  logic [tcst_pkg::IdxW:0] pos_r, pos_nxt;

  // State and position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcst_pkg::S_IDLE;
      pos_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r;
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      tcst_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (in_kind == tcst_pkg::KIND_ADD) begin
            if (sts.count >= (tcst_pkg::CntW)'(tcst_pkg::Capacity)) begin
              cmd.emit = 1'b1;
              cmd.emit_kind = tcst_pkg::RES_ACK;
              cmd.emit_full = tcst_pkg::ST_FULL;
              state_nxt = tcst_pkg::S_DONE;
            end else begin
              pos_nxt = (tcst_pkg::IdxW+1)'(sts.count);
              state_nxt = (sts.count == '0) ? tcst_pkg::S_INSERT : tcst_pkg::S_SHIFT_RD;
            end
          end else begin
            pos_nxt = '0;
            state_nxt = tcst_pkg::S_SCAN_RD;
          end
        end
      end
      // Read entry below the hole
      tcst_pkg::S_SHIFT_RD: begin
        cmd.rd = 1'b1;
        cmd.rd_addr = tcst_pkg::IdxW'(pos_r - 1'b1);
        state_nxt = tcst_pkg::S_SHIFT_WR;
      end
      // Move it up if later than the new time, else insert
      tcst_pkg::S_SHIFT_WR: begin
        if (sts.rd_gt) begin
          cmd.wr = 1'b1;
          cmd.wr_addr = tcst_pkg::IdxW'(pos_r);
          pos_nxt = pos_r - 1'b1;
          state_nxt = (pos_r == (tcst_pkg::IdxW+1)'(1)) ? tcst_pkg::S_INSERT
                                                         : tcst_pkg::S_SHIFT_RD;
        end else begin
          state_nxt = tcst_pkg::S_INSERT;
        end
      end
      tcst_pkg::S_INSERT: begin
        cmd.wr = 1'b1;
        cmd.wr_sel = 1'b1;
        cmd.wr_addr = tcst_pkg::IdxW'(pos_r);
        cmd.inc_count = 1'b1;
        cmd.emit = 1'b1;
        cmd.emit_kind = tcst_pkg::RES_ACK;
        cmd.emit_full = tcst_pkg::ST_OK;
        cmd.emit_slot = pos_r;
        state_nxt = tcst_pkg::S_DONE;
      end
      tcst_pkg::S_SCAN_RD: begin
        if (pos_r >= (tcst_pkg::IdxW+1)'(sts.count)) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = tcst_pkg::RES_SUM;
          state_nxt = tcst_pkg::S_DONE;
        end else begin
          cmd.rd = 1'b1;
          cmd.rd_addr = tcst_pkg::IdxW'(pos_r);
          state_nxt = tcst_pkg::S_SCAN_CHK;
        end
      end
      // Fire and mark done on a hit
      tcst_pkg::S_SCAN_CHK: begin
        if (sts.rd_hit) begin
          cmd.wr = 1'b1;
          cmd.wr_mark = 1'b1;
          cmd.wr_addr = tcst_pkg::IdxW'(pos_r);
          cmd.inc_fired = 1'b1;
          cmd.emit = 1'b1;
          cmd.emit_kind = tcst_pkg::RES_FIRE;
        end
        pos_nxt = pos_r + 1'b1;
        state_nxt = tcst_pkg::S_SCAN_RD;
      end
      tcst_pkg::S_DONE: begin
        state_nxt = tcst_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tcst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: design/timed_command_schedule_table_unit.sv
// Time-sorted command table. Assert start while busy is low to transfer an
// add or apply item. An add moves later entries up one at a time, each read
// and then written one slot higher, and writes the new entry into the freed
// slot; when the slot is above 0, a read and compare of the entry below it
// stops the move. A full table answers with a full status and stores nothing.
// An apply reads each stored entry, up to 32, through the single RAM port.
// Results appear for one cycle on out_valid and cannot be stalled; every
// item ends with a result whose last bit is set.
module timed_command_schedule_table_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tcst_pkg::in_item_t  in_data,
  output logic                out_valid,
  output tcst_pkg::out_item_t out_data
);

  tcst_pkg::dp_cmd_t cmd;
  tcst_pkg::dp_sts_t sts;

  tcst_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_kind(in_data.kind),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  tcst_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
